### design/sgl_pkg.sv
// types, constants and helper functions shared by the glyph segmenter modules
package sgl_pkg;

    localparam logic [15:0] KANJI0_LO   = 16'h8140;
    localparam logic [15:0] KANJI0_HI   = 16'h9ffc;
    localparam logic [15:0] KANJI1_LO   = 16'he040;
    localparam logic [15:0] KANJI1_HI   = 16'heffc;
    localparam int          ROW_SPAN    = 192;
    localparam int          ROW_KEEP    = ROW_SPAN - 4;
    localparam int          BANK1_ROWS  = (15 + 32 + 15) / 2;
    localparam int          GAP_COL     = 62;
    localparam logic [14:0] ROM_BASE    = 15'h100;
    localparam logic [7:0]  TRAIL_LO    = 8'h40;
    localparam logic [7:0]  TRAIL_HI    = 8'hfc;
    localparam logic [7:0]  TRAIL_HOLE  = 8'h7f;
    localparam logic [19:0] WIDTH_MAX   = 20'd524280;
    localparam logic [15:0] COUNT_MAX   = 16'hffff;
    localparam logic [4:0]  NARROW_W    = 5'd8;
    localparam logic [4:0]  WIDE_W      = 5'd16;

    typedef struct packed {
        logic        wide_glyph;
        logic [15:0] char_code;
        logic [14:0] rom_offset;
        logic [18:0] x_position;
        logic        glyph_fits;
        logic [15:0] fitted_bytes;
        logic [18:0] total_width;
        logic        run_end;
    } sgl_result_t;

    typedef struct packed {
        logic [19:0] width_sum;
        logic [15:0] fit_count;
        logic        fit_stopped;
    } sgl_acc_t;

    typedef struct packed {
        sgl_result_t res;
        sgl_acc_t    acc;
    } sgl_emit_t;

    typedef struct packed {
        logic        two;
        sgl_result_t res0;
        sgl_result_t res1;
    } sgl_entry_t;

    typedef struct packed {
        logic full;
        logic last_free;
    } sgl_qstat_t;

    function automatic logic is_lead(logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
    endfunction

    function automatic logic is_trail(logic [7:0] b);
        return (b != TRAIL_HOLE) && (b >= TRAIL_LO) && (b <= TRAIL_HI);
    endfunction

    // offset of a kanji pair in a font row, zero for unmapped codes
    function automatic logic [14:0] pair_offset(logic [15:0] code);
        logic [5:0]  row;
        logic [7:0]  col;
        logic [14:0] idx;
        logic        mapped;
        col    = code[7:0] - TRAIL_LO;
        row    = '0;
        mapped = 1'b0;
        if (code >= KANJI0_LO && code <= KANJI0_HI)
        begin
            row    = {1'b0, code[12:8]} - 6'd1;
            mapped = 1'b1;
        end
        else if (code >= KANJI1_LO && code <= KANJI1_HI)
        begin
            row    = {2'b00, code[11:8]} + 6'(BANK1_ROWS);
            mapped = 1'b1;
        end
        idx = 15'(row) * 15'(ROW_KEEP) + 15'(col) - 15'(col > 8'(GAP_COL));
        return mapped ? (ROM_BASE + {idx[13:0], 1'b0}) : 15'd0;
    endfunction

    // one glyph: running width, fit decision and result fields
    function automatic sgl_emit_t emit_glyph(sgl_acc_t acc, logic wide, logic [15:0] code,
                                             logic last, logic [15:0] fit_width);
        sgl_emit_t   e;
        logic [20:0] sum;
        logic [19:0] after;
        logic [16:0] cnt_sum;
        logic        fits;
        sum     = {1'b0, acc.width_sum} + 21'(wide ? WIDE_W : NARROW_W);
        after   = (sum > {1'b0, WIDTH_MAX}) ? WIDTH_MAX : sum[19:0];
        fits    = !acc.fit_stopped && (sum <= {5'd0, fit_width});
        cnt_sum = {1'b0, acc.fit_count} + (wide ? 17'd2 : 17'd1);
        e.acc.width_sum   = after;
        e.acc.fit_stopped = acc.fit_stopped || !fits;
        if (fits)
        begin
            e.acc.fit_count = cnt_sum[16] ? COUNT_MAX : cnt_sum[15:0];
        end
        else
        begin
            e.acc.fit_count = acc.fit_count;
        end
        e.res.wide_glyph   = wide;
        e.res.char_code    = code;
        e.res.rom_offset   = wide ? pair_offset(code) : {7'd0, code[7:0]};
        e.res.x_position   = acc.width_sum[18:0];
        e.res.glyph_fits   = fits;
        e.res.fitted_bytes = e.acc.fit_count;
        e.res.total_width  = after[18:0];
        e.res.run_end      = last;
        return e;
    endfunction

endpackage

### design/sgl_seg_core.sv
// glyph segmentation and width fitting for one registered byte
module sgl_seg_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          text_byte,
    input  logic                is_final,
    input  logic [15:0]         fit_width,
    output logic                push,
    output sgl_pkg::sgl_entry_t entry
);
    import sgl_pkg::*;

    logic       [7:0] held_lead_reg, held_lead_next;
    logic             lead_pending_reg, lead_pending_next;
    sgl_acc_t         acc_reg, acc_next;

    logic             pend_trail;
    logic             emit_b;
    logic             g0_valid;
    logic             g1_valid;
    logic      [15:0] g0_code;
    logic             g0_last;
    sgl_emit_t        e0;
    sgl_emit_t        e1;

    always_comb
    begin
        pend_trail = lead_pending_reg && is_trail(text_byte);
        emit_b     = !(is_lead(text_byte) && !is_final);
        g0_valid   = lead_pending_reg || emit_b;
        g1_valid   = lead_pending_reg && !pend_trail && emit_b;
        if (pend_trail)
        begin
            g0_code = {held_lead_reg, text_byte};
            g0_last = is_final;
        end
        else if (lead_pending_reg)
        begin
            g0_code = {8'd0, held_lead_reg};
            g0_last = 1'b0;
        end
        else
        begin
            g0_code = {8'd0, text_byte};
            g0_last = is_final;
        end
        e0 = emit_glyph(acc_reg, pend_trail, g0_code, g0_last, fit_width);
        e1 = emit_glyph(e0.acc, 1'b0, {8'd0, text_byte}, is_final, fit_width);

        push       = in_valid && g0_valid;
        entry.two  = g1_valid;
        entry.res0 = e0.res;
        entry.res1 = e1.res;

        acc_next          = acc_reg;
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        if (in_valid)
        begin
            if (is_final)
            begin
                acc_next          = '0;
                held_lead_next    = '0;
                lead_pending_next = 1'b0;
            end
            else
            begin
                if (g1_valid)
                begin
                    acc_next = e1.acc;
                end
                else if (g0_valid)
                begin
                    acc_next = e0.acc;
                end
                if (is_lead(text_byte) && !pend_trail)
                begin
                    held_lead_next    = text_byte;
                    lead_pending_next = 1'b1;
                end
                else
                begin
                    lead_pending_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
        end
        else
        begin
            acc_reg          <= acc_next;
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
        end
    end

    a_held_is_lead: assert property (@(posedge clk) disable iff (!rst_n)
        lead_pending_reg |-> is_lead(held_lead_reg))
        else $error("held byte is not a lead byte");

    a_stopped_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && acc_reg.fit_stopped && !is_final) |=> $stable(acc_reg.fit_count))
        else $error("fitted byte count moved after overflow");

    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg.width_sum <= WIDTH_MAX)
        else $error("width sum beyond saturation");

endmodule

### design/sgl_out_queue.sv
// result queue holding one or two glyphs per entry, drained one glyph per transaction
module sgl_out_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sgl_pkg::sgl_entry_t  push_entry,
    output sgl_pkg::sgl_qstat_t  stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sgl_pkg::sgl_result_t out_result
);
    import sgl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sgl_entry_t             mem [DEPTH];
    logic       [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic       [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic       [CNT_W-1:0] count_reg, count_next;
    logic                   sub_reg, sub_next;
    sgl_entry_t             head;
    logic                   take;
    logic                   pop;

    always_comb
    begin
        head       = mem[rd_ptr_reg];
        out_valid  = (count_reg != '0);
        out_result = sub_reg ? head.res1 : head.res0;
        take       = out_valid && out_ready;
        pop        = take && (sub_reg || !head.two);
        stat.full      = (count_reg == CNT_W'(DEPTH));
        stat.last_free = (count_reg == CNT_W'(DEPTH - 1));

        sub_next = sub_reg;
        if (pop)
        begin
            sub_next = 1'b0;
        end
        else if (take)
        begin
            sub_next = 1'b1;
        end

        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end

        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into a full result queue");

    a_second_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (out_valid && head.two))
        else $error("second glyph selected on a single-glyph entry");

endmodule

### design/sjis_glyph_locate_and_fit_unit.sv
// top level of the two-byte text glyph segmenter with width fitting
// a taken byte is held in an input register, then its glyphs are written into the result queue and leave from its head
// throughput: one byte per cycle while the queue has room; a two-glyph byte needs two output transactions
// a lead byte awaiting its trail byte yields no glyph until the next byte arrives
// reset clears run state and queue, fit_width returns to 65535; no clearing pass
module sjis_glyph_locate_and_fit_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // fit_width
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // char_code, rom_offset, x_position, glyph_fits,
                                        // fitted_bytes, total_width, zero pad
    output logic        m_axis_tuser,   // wide_glyph
    output logic        m_axis_tlast    // run_end
);
    import sgl_pkg::*;

    logic [15:0]  fit_width_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_final_reg;
    logic         push;
    sgl_entry_t   entry;
    sgl_qstat_t   qstat;
    sgl_result_t  res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !qstat.full && !(in_valid_reg && qstat.last_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_width_reg <= 16'hffff;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fit_width_reg <= cfg_data;
            end
            in_valid_reg <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_final_reg <= s_axis_tlast;
        end
    end

    sgl_seg_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .text_byte (in_byte_reg),
        .is_final  (in_final_reg),
        .fit_width (fit_width_reg),
        .push      (push),
        .entry     (entry)
    );

    sgl_out_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .stat       (qstat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tdata = {2'b00, res.total_width, res.fitted_bytes, res.glyph_fits,
                           res.x_position, res.rom_offset, res.char_code};
    assign m_axis_tuser = res.wide_glyph;
    assign m_axis_tlast = res.run_end;

    a_room_for_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> !qstat.full)
        else $error("registered byte has no queue room");

endmodule
